// ===== src/gap_buffer_text_store_macros.svh =====
// Assertion macros shared by the gap buffer text store
`ifndef GAP_BUFFER_TEXT_STORE_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define GBTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gap buffer assertion failed");
// Next-cycle implication
`define GBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gap buffer assertion failed");
`else
`define GBTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/gbts_pkg.sv =====
package gbts_pkg;

	localparam logic [7:0] NEWLINE = 8'd10;

	// Operation codes
	localparam logic [3:0] OP_PUT_BYTE   = 4'd0;
	localparam logic [3:0] OP_DELETE     = 4'd1;
	localparam logic [3:0] OP_BACKSPACE  = 4'd2;
	localparam logic [3:0] OP_MOVE_REL   = 4'd3;
	localparam logic [3:0] OP_MOVE_TO    = 4'd4;
	localparam logic [3:0] OP_LINE_MOVE  = 4'd5;
	localparam logic [3:0] OP_GOTO_LINE  = 4'd6;
	localparam logic [3:0] OP_READ       = 4'd7;
	localparam logic [3:0] OP_LINE_START = 4'd8;
	localparam logic [3:0] OP_LINE_END   = 4'd9;

	// Status codes
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_BOUNDARY = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// Datapath commands issued by the controller
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_DISPATCH,
		CMD_SHIFT_RD,
		CMD_SHIFT_WR,
		CMD_INS,
		CMD_DEL,
		CMD_BS_RD,
		CMD_BS_EV,
		CMD_RD_BACK,
		CMD_BACK_STEP,
		CMD_BACK_END,
		CMD_RD_CUR,
		CMD_FWD_STEP,
		CMD_RD_PTR,
		CMD_CNT_STEP,
		CMD_TARGET,
		CMD_SOL_END,
		CMD_PTR_INC,
		CMD_EOL_END,
		CMD_PLACE_INIT,
		CMD_PLACE_STEP,
		CMD_RD_POS,
		CMD_READ_END
	} cmd_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic [3:0] op;
		logic       full;
		logic       at_end;
		logic       at_start;
		logic       gap_move;
		logic       step_pos;
		logic       pos_ge_len;
		logic       ptr_zero;
		logic       ptr_ge_len;
		logic       ptr_ge_cur;
		logic       sol_done;
		logic       rd_nl;
	} status_t;

endpackage

// ===== src/gbts_if.sv =====
interface gbts_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         operation;
	logic [7:0]         char_in;
	logic [12:0]        position;
	logic signed [13:0] step;

	modport source (output valid, operation, char_in, position, step, input ready);
	modport sink (input valid, operation, char_in, position, step, output ready);
endinterface

interface gbts_rsp_if;
	logic        valid;
	logic        ready;
	logic [12:0] cursor_pos;
	logic [12:0] line_num;
	logic [12:0] col_num;
	logic [12:0] text_length;
	logic [7:0]  char_out;
	logic        dirty;
	logic [1:0]  status;

	modport source (output valid, cursor_pos, line_num, col_num, text_length, char_out, dirty,
		status, input ready);
	modport sink (input valid, cursor_pos, line_num, col_num, text_length, char_out, dirty,
		status, output ready);
endinterface

// ===== src/gbts_dp.sv =====
`include "gap_buffer_text_store_macros.svh"

module gbts_dp import gbts_pkg::*; #(
	parameter int CAPACITY = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [3:0]         operation,
	input  logic [7:0]         char_in,
	input  logic [12:0]        position,
	input  logic signed [13:0] step,
	output status_t            st,
	output logic [12:0]        cursor_pos,
	output logic [12:0]        line_num,
	output logic [12:0]        col_num,
	output logic [12:0]        text_length,
	output logic [7:0]         char_out,
	output logic               dirty,
	output logic [1:0]         status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int TW = (CW > 13) ? CW : 13;
	localparam int XW = TW + 2;

	logic [3:0]         op_q;
	logic [7:0]         ch_q;
	logic [12:0]        pos_q;
	logic signed [13:0] step_q;
	logic [CW-1:0]      gap_low_q, gap_high_q, cursor_q, line_q, col_q, ptr_q, lstart_q;
	logic [TW-1:0]      cnt_q, tgt_q;
	logic               dirty_q;
	logic [7:0]         char_q;
	logic [1:0]         status_q;
	logic [7:0]         rdata_q;
	logic [7:0]         mem [CAPACITY];

	logic [CW-1:0]        len, gap_width, la, phys, raddr, waddr, span, col_sel;
	logic [7:0]           wdata;
	logic                 re, we, shift_left, shift_right, rd_nl;
	logic signed [XW-1:0] cur_x, len_x, step_x, pos_x, line_x, cnt_x, np_x, up_x, room_x, t_x;

	assign len         = CW'(CAPACITY) - (gap_high_q - gap_low_q);
	assign gap_width   = gap_high_q - gap_low_q;
	assign shift_left  = gap_low_q > cursor_q;
	assign shift_right = gap_low_q < cursor_q;
	assign rd_nl       = rdata_q == NEWLINE;

	assign cur_x  = $signed(XW'(cursor_q));
	assign len_x  = $signed(XW'(len));
	assign step_x = XW'(step_q);
	assign pos_x  = $signed(XW'(pos_q));
	assign line_x = $signed(XW'(line_q));
	assign cnt_x  = $signed(XW'(cnt_q));
	assign np_x   = cur_x + step_x;
	assign up_x   = -step_x;
	assign room_x = (cnt_x > line_x) ? cnt_x - line_x : '0;
	assign t_x    = (step_x > room_x) ? room_x : step_x;
	assign span   = ptr_q - lstart_q;
	assign col_sel = (col_q < span) ? col_q : span;

	// Pick the logical byte to read and map it past the gap
	always_comb begin
		case (cmd)
			CMD_RD_BACK: la = ptr_q - CW'(1);
			CMD_RD_CUR:  la = cursor_q;
			CMD_RD_POS:  la = CW'(pos_q);
			default:     la = ptr_q;
		endcase
		phys = (la < gap_low_q) ? la : la + gap_width;
		case (cmd)
			CMD_SHIFT_RD: raddr = shift_left ? gap_low_q - CW'(1) : gap_high_q;
			CMD_BS_RD:    raddr = gap_low_q - CW'(1);
			default:      raddr = phys;
		endcase
		re = (cmd == CMD_SHIFT_RD) || (cmd == CMD_BS_RD) || (cmd == CMD_RD_BACK) ||
			(cmd == CMD_RD_CUR) || (cmd == CMD_RD_PTR) || (cmd == CMD_RD_POS);
		we    = (cmd == CMD_SHIFT_WR) || (cmd == CMD_INS);
		waddr = (cmd == CMD_SHIFT_WR && shift_left) ? gap_high_q - CW'(1) : gap_low_q;
		wdata = (cmd == CMD_INS) ? ch_q : rdata_q;
	end

	// Text memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr[AW-1:0]] <= wdata;
		if (re)
			rdata_q <= mem[raddr[AW-1:0]];
	end

	// Execute the controller's command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= '0;
			ch_q       <= '0;
			pos_q      <= '0;
			step_q     <= '0;
			gap_low_q  <= '0;
			gap_high_q <= CW'(CAPACITY);
			cursor_q   <= '0;
			line_q     <= '0;
			col_q      <= '0;
			ptr_q      <= '0;
			lstart_q   <= '0;
			cnt_q      <= '0;
			tgt_q      <= '0;
			dirty_q    <= 1'b0;
			char_q     <= '0;
			status_q   <= ST_DONE;
		end else begin
			unique case (cmd)
				CMD_NONE: ;
				CMD_LOAD: begin
					op_q     <= operation;
					ch_q     <= char_in;
					pos_q    <= position;
					step_q   <= step;
					char_q   <= '0;
					status_q <= ST_DONE;
				end
				CMD_DISPATCH: begin
					ptr_q <= (op_q == OP_LINE_START) ? cursor_q : '0;
					cnt_q <= '0;
					unique case (op_q) inside
						OP_PUT_BYTE:
							if (len == CW'(CAPACITY))
								status_q <= ST_FULL;
						OP_DELETE:
							if (cursor_q >= len)
								status_q <= ST_BOUNDARY;
						OP_BACKSPACE:
							if (cursor_q == '0)
								status_q <= ST_BOUNDARY;
						OP_MOVE_REL:
							if (np_x < 0)
								tgt_q <= '0;
							else if (np_x > len_x)
								tgt_q <= TW'(len);
							else
								tgt_q <= TW'(np_x);
						OP_MOVE_TO:
							tgt_q <= (pos_x > len_x) ? TW'(len) : TW'(pos_q);
						OP_LINE_MOVE:
							if (step_q < 0)
								tgt_q <= TW'(line_x - ((up_x > line_x) ? line_x : up_x));
							else
								tgt_q <= TW'(line_q);
						OP_GOTO_LINE:
							tgt_q <= (pos_q == '0) ? '0 : TW'(pos_q - 13'd1);
						OP_READ, OP_LINE_START, OP_LINE_END: ;
						default:
							status_q <= ST_BOUNDARY;
					endcase
				end
				CMD_SHIFT_RD: ;
				CMD_SHIFT_WR: begin
					if (shift_left) begin
						gap_low_q  <= gap_low_q - CW'(1);
						gap_high_q <= gap_high_q - CW'(1);
					end else begin
						gap_low_q  <= gap_low_q + CW'(1);
						gap_high_q <= gap_high_q + CW'(1);
					end
				end
				CMD_INS: begin
					gap_low_q <= gap_low_q + CW'(1);
					cursor_q  <= cursor_q + CW'(1);
					dirty_q   <= 1'b1;
					if (ch_q == NEWLINE) begin
						line_q <= line_q + CW'(1);
						col_q  <= '0;
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				CMD_DEL: begin
					gap_high_q <= gap_high_q + CW'(1);
					dirty_q    <= 1'b1;
				end
				CMD_BS_RD: ;
				CMD_BS_EV: begin
					gap_low_q <= gap_low_q - CW'(1);
					cursor_q  <= cursor_q - CW'(1);
					ptr_q     <= cursor_q - CW'(1);
					dirty_q   <= 1'b1;
					if (rd_nl) begin
						if (line_q != '0)
							line_q <= line_q - CW'(1);
						col_q <= '0;
					end else if (col_q != '0) begin
						col_q <= col_q - CW'(1);
					end
				end
				CMD_RD_BACK, CMD_RD_CUR, CMD_RD_PTR, CMD_RD_POS: ;
				CMD_BACK_STEP: begin
					ptr_q <= ptr_q - CW'(1);
					col_q <= col_q + CW'(1);
				end
				CMD_BACK_END:
					if (op_q == OP_LINE_START) begin
						cursor_q <= ptr_q;
						col_q    <= '0;
					end
				CMD_FWD_STEP: begin
					cursor_q <= cursor_q + CW'(1);
					col_q    <= col_q + CW'(1);
				end
				CMD_CNT_STEP: begin
					if (rd_nl)
						cnt_q <= cnt_q + TW'(1);
					ptr_q <= ptr_q + CW'(1);
				end
				CMD_TARGET: begin
					tgt_q <= TW'(line_x + t_x);
					ptr_q <= '0;
					cnt_q <= '0;
				end
				CMD_SOL_END: begin
					lstart_q <= ptr_q;
					tgt_q    <= TW'(ptr_q);
				end
				CMD_PTR_INC:
					ptr_q <= ptr_q + CW'(1);
				CMD_EOL_END:
					tgt_q <= TW'(lstart_q + col_sel);
				CMD_PLACE_INIT: begin
					cursor_q <= tgt_q[CW-1:0];
					line_q   <= '0;
					col_q    <= '0;
					ptr_q    <= '0;
				end
				CMD_PLACE_STEP: begin
					if (rd_nl) begin
						line_q <= line_q + CW'(1);
						col_q  <= '0;
					end else begin
						col_q <= col_q + CW'(1);
					end
					ptr_q <= ptr_q + CW'(1);
				end
				CMD_READ_END:
					char_q <= rdata_q;
				default: ;
			endcase
		end
	end

	// Status toward the controller
	always_comb begin
		st.op         = op_q;
		st.full       = len == CW'(CAPACITY);
		st.at_end     = cursor_q >= len;
		st.at_start   = cursor_q == '0;
		st.gap_move   = shift_left || shift_right;
		st.step_pos   = step_q > 0;
		st.pos_ge_len = pos_x >= len_x;
		st.ptr_zero   = ptr_q == '0;
		st.ptr_ge_len = ptr_q >= len;
		st.ptr_ge_cur = ptr_q >= cursor_q;
		st.sol_done   = cnt_q >= tgt_q;
		st.rd_nl      = rd_nl;
	end

	assign cursor_pos  = 13'(cursor_q);
	assign line_num    = 13'(line_q);
	assign col_num     = 13'(col_q);
	assign text_length = 13'(len);
	assign char_out    = char_q;
	assign dirty       = dirty_q;
	assign status      = status_q;

	`GBTS_ASSERT_IMPL(a_gap_order, clk, arst_n, 1'b1, gap_low_q <= gap_high_q)
	`GBTS_ASSERT_IMPL(a_cursor_in_text, clk, arst_n, 1'b1, cursor_q <= len)
	`GBTS_ASSERT_NEXT(a_dirty_sticky, clk, arst_n, dirty_q, dirty_q)
	`GBTS_ASSERT_NEXT(a_ins_grows, clk, arst_n, cmd == CMD_INS, len == CW'($past(len) + 1'b1))

endmodule

// ===== src/gbts_ctrl.sv =====
module gbts_ctrl import gbts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_SHIFT_CHK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_EDIT,
		S_BS_EV,
		S_BACK_CHK,
		S_BACK_EV,
		S_FWD_CHK,
		S_FWD_EV,
		S_CNT_CHK,
		S_CNT_EV,
		S_TARGET,
		S_SOL_CHK,
		S_SOL_EV,
		S_EOL_CHK,
		S_EOL_EV,
		S_PLACE_INIT,
		S_PLACE_CHK,
		S_PLACE_EV,
		S_READ_RD,
		S_READ_EV,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = state_q == S_DONE;

	// Sequence the datapath through each operation
	always_comb begin
		cmd     = CMD_NONE;
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_DISPATCH;
				end
			S_DISPATCH: begin
				cmd = CMD_DISPATCH;
				unique case (st.op) inside
					OP_PUT_BYTE:             state_d = st.full ? S_DONE : S_SHIFT_CHK;
					OP_DELETE:               state_d = st.at_end ? S_DONE : S_SHIFT_CHK;
					OP_BACKSPACE:            state_d = st.at_start ? S_DONE : S_SHIFT_CHK;
					OP_MOVE_REL, OP_MOVE_TO: state_d = S_PLACE_INIT;
					OP_LINE_MOVE:            state_d = st.step_pos ? S_CNT_CHK : S_SOL_CHK;
					OP_GOTO_LINE:            state_d = S_SOL_CHK;
					OP_READ:                 state_d = st.pos_ge_len ? S_DONE : S_READ_RD;
					OP_LINE_START:           state_d = S_BACK_CHK;
					OP_LINE_END:             state_d = S_FWD_CHK;
					default:                 state_d = S_DONE;
				endcase
			end
			S_SHIFT_CHK:
				state_d = st.gap_move ? S_SHIFT_RD : S_EDIT;
			S_SHIFT_RD: begin
				cmd     = CMD_SHIFT_RD;
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd     = CMD_SHIFT_WR;
				state_d = S_SHIFT_CHK;
			end
			S_EDIT:
				unique case (st.op) inside
					OP_PUT_BYTE: begin
						cmd     = CMD_INS;
						state_d = S_DONE;
					end
					OP_DELETE: begin
						cmd     = CMD_DEL;
						state_d = S_DONE;
					end
					default: begin
						cmd     = CMD_BS_RD;
						state_d = S_BS_EV;
					end
				endcase
			S_BS_EV: begin
				cmd     = CMD_BS_EV;
				state_d = st.rd_nl ? S_BACK_CHK : S_DONE;
			end
			S_BACK_CHK:
				if (st.ptr_zero) begin
					cmd     = CMD_BACK_END;
					state_d = S_DONE;
				end else begin
					cmd     = CMD_RD_BACK;
					state_d = S_BACK_EV;
				end
			S_BACK_EV:
				if (st.rd_nl) begin
					cmd     = CMD_BACK_END;
					state_d = S_DONE;
				end else begin
					cmd     = CMD_BACK_STEP;
					state_d = S_BACK_CHK;
				end
			S_FWD_CHK:
				if (st.at_end) begin
					state_d = S_DONE;
				end else begin
					cmd     = CMD_RD_CUR;
					state_d = S_FWD_EV;
				end
			S_FWD_EV:
				if (st.rd_nl) begin
					state_d = S_DONE;
				end else begin
					cmd     = CMD_FWD_STEP;
					state_d = S_FWD_CHK;
				end
			S_CNT_CHK:
				if (st.ptr_ge_len) begin
					state_d = S_TARGET;
				end else begin
					cmd     = CMD_RD_PTR;
					state_d = S_CNT_EV;
				end
			S_CNT_EV: begin
				cmd     = CMD_CNT_STEP;
				state_d = S_CNT_CHK;
			end
			S_TARGET: begin
				cmd     = CMD_TARGET;
				state_d = S_SOL_CHK;
			end
			S_SOL_CHK:
				if (st.sol_done || st.ptr_ge_len) begin
					cmd     = CMD_SOL_END;
					state_d = (st.op == OP_GOTO_LINE) ? S_PLACE_INIT : S_EOL_CHK;
				end else begin
					cmd     = CMD_RD_PTR;
					state_d = S_SOL_EV;
				end
			S_SOL_EV: begin
				cmd     = CMD_CNT_STEP;
				state_d = S_SOL_CHK;
			end
			S_EOL_CHK:
				if (st.ptr_ge_len) begin
					cmd     = CMD_EOL_END;
					state_d = S_PLACE_INIT;
				end else begin
					cmd     = CMD_RD_PTR;
					state_d = S_EOL_EV;
				end
			S_EOL_EV:
				if (st.rd_nl) begin
					cmd     = CMD_EOL_END;
					state_d = S_PLACE_INIT;
				end else begin
					cmd     = CMD_PTR_INC;
					state_d = S_EOL_CHK;
				end
			S_PLACE_INIT: begin
				cmd     = CMD_PLACE_INIT;
				state_d = S_PLACE_CHK;
			end
			S_PLACE_CHK:
				if (st.ptr_ge_cur) begin
					state_d = S_DONE;
				end else begin
					cmd     = CMD_RD_PTR;
					state_d = S_PLACE_EV;
				end
			S_PLACE_EV: begin
				cmd     = CMD_PLACE_STEP;
				state_d = S_PLACE_CHK;
			end
			S_READ_RD: begin
				cmd     = CMD_RD_POS;
				state_d = S_READ_EV;
			end
			S_READ_EV: begin
				cmd     = CMD_READ_END;
				state_d = S_DONE;
			end
			S_DONE:
				if (out_ready)
					state_d = S_IDLE;
			default:
				state_d = S_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== src/gap_buffer_text_store.sv =====
// Rejected edits, unused codes and reads past the end finish soonest; other reads, and edits with
// the gap already at the cursor, take longer. Each byte the gap travels adds time; backspace adds
// a step, and after a removed newline it rescans the line before the cursor byte by byte. Cursor
// moves, line moves and line scans walk the text byte by byte.
// Throughput: one item at a time, next item taken the cycle after the result transfer.
// Reset: asynchronous, active low; empty text, cursor at line 0 column 0, clean; memory untouched.
module gap_buffer_text_store import gbts_pkg::*; #(
	parameter int CAPACITY = 4096
) (
	input logic        clk,
	input logic        arst_n,
	gbts_req_if.sink   req,
	gbts_rsp_if.source rsp
);

	cmd_t    cmd;
	status_t st;

	gbts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	gbts_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (req.operation),
		.char_in     (req.char_in),
		.position    (req.position),
		.step        (req.step),
		.st          (st),
		.cursor_pos  (rsp.cursor_pos),
		.line_num    (rsp.line_num),
		.col_num     (rsp.col_num),
		.text_length (rsp.text_length),
		.char_out    (rsp.char_out),
		.dirty       (rsp.dirty),
		.status      (rsp.status)
	);

endmodule
